// ===== design/chte_pkg.sv =====
package chte_pkg;

   localparam int unsigned DATA_W       = 32;
   localparam int unsigned STEP_W       = 31;
   localparam int unsigned FRAC_W       = 16;
   localparam int unsigned ENTRY_W      = 10;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned REQ_FIELDS_W = ENTRY_W + 5 * DATA_W;
   localparam int unsigned REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_TDATA_W  = 2 * DATA_W;
   localparam int unsigned WIDE_W       = 49;
   localparam int unsigned PROD_W       = 65;
   localparam int unsigned FIFO_DEPTH   = 16;
   localparam int unsigned FIFO_PTR_W   = 4;
   localparam int unsigned FIFO_CNT_W   = FIFO_PTR_W + 1;

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 49'sd2147483647;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -49'sd2147483648;

   typedef enum logic {
      CMD_QUERY = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_LOW       = 3'd0,
      CSR_X_HIGH      = 3'd1,
      CSR_STEP        = 3'd2,
      CSR_INV_STEP    = 3'd3,
      CSR_INV_STEP_SQ = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x_low;
      logic signed [DATA_W-1:0] x_high;
      logic [STEP_W-1:0]        step;
      logic [DATA_W-1:0]        inv_step;
      logic [DATA_W-1:0]        inv_step_sq;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      x_low:       32'sd0,
      x_high:      32'sd65536,
      step:        31'd64,
      inv_step:    32'd67108864,
      inv_step_sq: 32'd0
   };

   typedef struct packed {
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] d;
   } coef_type;

   typedef struct packed {
      logic              valid;
      cmd_type           cmd;
      logic              wr_ok;
      logic              below;
      logic [DATA_W-1:0] off;
   } access_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] derivative;
      logic                     below_range;
   } rsp_item_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_MAX) begin
         return 32'h7FFF_FFFF;
      end
      if (v < WIDE_MIN) begin
         return 32'h8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   // Q16.16 product scaled back with floor rounding, then saturated.
   function automatic logic signed [DATA_W-1:0] mulq(input logic signed [PROD_W-1:0] p);
      return sat32($signed(p[PROD_W-1:FRAC_W]));
   endfunction

endpackage

// ===== design/chte_ram.sv =====
module chte_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/chte_locate.sv =====
module chte_locate #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  chte_pkg::cmd_type                       in_cmd,
   input  logic [chte_pkg::ENTRY_W-1:0]            in_entry,
   input  chte_pkg::coef_type                      in_coef,
   input  logic signed [chte_pkg::DATA_W-1:0]      in_x,
   input  chte_pkg::cfg_type                       cfg,
   output chte_pkg::access_type                    acc,
   output logic [$clog2(TABLE_DEPTH)-1:0]          idx,
   output logic [$clog2(TABLE_DEPTH)-1:0]          entry_addr,
   output chte_pkg::coef_type                      coef
);

   import chte_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [DATA_W-1:0] IDX_MAX = DATA_W'(TABLE_DEPTH - 1);

   logic                     a_vld_ff;
   cmd_type                  a_cmd_ff;
   logic [ENTRY_W-1:0]       a_entry_ff;
   coef_type                 a_coef_ff;
   logic signed [DATA_W-1:0] a_x_ff;

   logic                     b_vld_ff;
   cmd_type                  b_cmd_ff;
   logic [ENTRY_W-1:0]       b_entry_ff;
   coef_type                 b_coef_ff;
   logic                     b_below_ff;
   logic                     b_below_in;
   logic [DATA_W-1:0]        b_off_ff;
   logic [DATA_W-1:0]        b_off_in;
   logic signed [DATA_W:0]   x_clamp;
   logic signed [DATA_W+1:0] off_wide;

   logic                     c_vld_ff;
   cmd_type                  c_cmd_ff;
   logic [ENTRY_W-1:0]       c_entry_ff;
   coef_type                 c_coef_ff;
   logic                     c_below_ff;
   logic [DATA_W-1:0]        c_off_ff;
   logic [DATA_W-1:0]        c_idx_ff;
   logic [DATA_W-1:0]        c_idx_in;
   logic [2*DATA_W-1:0]      idx_prod;

   logic                     d_vld_ff;
   cmd_type                  d_cmd_ff;
   coef_type                 d_coef_ff;
   logic                     d_below_ff;
   logic [DATA_W-1:0]        d_off_ff;
   logic [ADDR_W-1:0]        d_idx_ff;
   logic [ADDR_W-1:0]        d_idx_in;
   logic [ADDR_W-1:0]        d_entry_ff;
   logic [ADDR_W-1:0]        d_entry_in;
   logic                     d_wr_ok_ff;
   logic                     d_wr_ok_in;
   logic [DATA_W-1:0]        entry_ext;

   // A query above the range is clamped one LSB under the upper limit; an offset
   // that ends up negative selects the first entry with a zero offset.
   always_comb begin
      b_below_in = a_x_ff < cfg.x_low;
      if (a_x_ff >= cfg.x_high) begin
         x_clamp = (DATA_W+1)'(cfg.x_high) - (DATA_W+1)'(1);
      end else begin
         x_clamp = (DATA_W+1)'(a_x_ff);
      end
      off_wide = (DATA_W+2)'(x_clamp) - (DATA_W+2)'(cfg.x_low);
      b_off_in = off_wide[DATA_W+1] ? '0 : off_wide[DATA_W-1:0];
   end

   always_comb begin
      idx_prod = (2*DATA_W)'(b_off_ff) * (2*DATA_W)'(cfg.inv_step);
      c_idx_in = idx_prod[2*DATA_W-1:DATA_W];
   end

   always_comb begin
      d_idx_in   = (c_idx_ff > IDX_MAX) ? ADDR_W'(TABLE_DEPTH - 1) : c_idx_ff[ADDR_W-1:0];
      entry_ext  = DATA_W'(c_entry_ff);
      d_wr_ok_in = entry_ext < DATA_W'(TABLE_DEPTH);
      d_entry_in = entry_ext[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_cmd_ff   <= in_cmd;
      a_entry_ff <= in_entry;
      a_coef_ff  <= in_coef;
      a_x_ff     <= in_x;

      b_cmd_ff   <= a_cmd_ff;
      b_entry_ff <= a_entry_ff;
      b_coef_ff  <= a_coef_ff;
      b_below_ff <= b_below_in;
      b_off_ff   <= b_off_in;

      c_cmd_ff   <= b_cmd_ff;
      c_entry_ff <= b_entry_ff;
      c_coef_ff  <= b_coef_ff;
      c_below_ff <= b_below_ff;
      c_off_ff   <= b_off_ff;
      c_idx_ff   <= c_idx_in;

      d_cmd_ff   <= c_cmd_ff;
      d_coef_ff  <= c_coef_ff;
      d_below_ff <= c_below_ff;
      d_off_ff   <= c_off_ff;
      d_idx_ff   <= d_idx_in;
      d_entry_ff <= d_entry_in;
      d_wr_ok_ff <= d_wr_ok_in;
   end

   always_comb begin
      acc.valid = d_vld_ff;
      acc.cmd   = d_cmd_ff;
      acc.wr_ok = d_wr_ok_ff;
      acc.below = d_below_ff;
      acc.off   = d_off_ff;
   end

   assign idx        = d_idx_ff;
   assign entry_addr = d_entry_ff;
   assign coef       = d_coef_ff;

endmodule

// ===== design/chte_eval.sv =====
module chte_eval #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  chte_pkg::access_type           acc,
   input  logic [$clog2(TABLE_DEPTH)-1:0] idx,
   input  chte_pkg::coef_type             rd_coef,
   input  chte_pkg::cfg_type              cfg,
   output logic                           out_valid,
   output chte_pkg::rsp_item_type         out_item
);

   import chte_pkg::*;

   localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int unsigned ISTEP_W = ADDR_W + STEP_W;
   localparam int unsigned LAST    = 9;

   logic [LAST:1] vld_ff;
   logic [LAST:1] vld_in;

   logic                     s1_below_ff;
   logic [DATA_W-1:0]        s1_off_ff;
   logic [ISTEP_W-1:0]       s1_istep_ff;
   logic [ISTEP_W-1:0]       s1_istep_in;

   logic                     s2_below_ff;
   coef_type                 s2_coef_ff;
   logic signed [DATA_W-1:0] s2_t_ff;
   logic signed [DATA_W-1:0] s2_t_in;
   logic signed [WIDE_W-1:0] t_wide;

   logic                     s3_below_ff;
   logic signed [DATA_W-1:0] s3_t_ff;
   coef_type                 s3_coef_ff;
   logic signed [PROD_W-1:0] s3_p_td_ff;
   logic signed [PROD_W-1:0] s3_p_td_in;
   logic signed [PROD_W-1:0] s3_p_tc_ff;
   logic signed [PROD_W-1:0] s3_p_tc_in;
   logic signed [PROD_W-1:0] s3_p_tt_ff;
   logic signed [PROD_W-1:0] s3_p_tt_in;

   logic                     s4_below_ff;
   logic signed [DATA_W-1:0] s4_t_ff;
   logic signed [DATA_W-1:0] s4_a_ff;
   logic signed [DATA_W-1:0] s4_b_ff;
   logic signed [DATA_W-1:0] s4_d_ff;
   logic signed [DATA_W-1:0] s4_sum_ff;
   logic signed [DATA_W-1:0] s4_sum_in;
   logic signed [DATA_W-1:0] s4_two_ff;
   logic signed [DATA_W-1:0] s4_two_in;
   logic signed [DATA_W-1:0] s4_tt_ff;
   logic signed [DATA_W-1:0] s4_tt_in;

   logic                     s5_below_ff;
   logic signed [DATA_W-1:0] s5_t_ff;
   logic signed [DATA_W-1:0] s5_a_ff;
   logic signed [DATA_W-1:0] s5_b_ff;
   logic signed [DATA_W-1:0] s5_two_ff;
   logic signed [PROD_W-1:0] s5_p_ts_ff;
   logic signed [PROD_W-1:0] s5_p_ts_in;
   logic signed [PROD_W-1:0] s5_p_ttd_ff;
   logic signed [PROD_W-1:0] s5_p_ttd_in;

   logic                     s6_below_ff;
   logic signed [DATA_W-1:0] s6_t_ff;
   logic signed [DATA_W-1:0] s6_a_ff;
   logic signed [DATA_W-1:0] s6_b_ff;
   logic signed [DATA_W-1:0] s6_m2_ff;
   logic signed [DATA_W-1:0] s6_m2_in;
   logic signed [DATA_W-1:0] s6_sum3_ff;
   logic signed [DATA_W-1:0] s6_sum3_in;
   logic signed [DATA_W-1:0] three;

   logic                     s7_below_ff;
   logic signed [DATA_W-1:0] s7_t_ff;
   logic signed [DATA_W-1:0] s7_a_ff;
   logic signed [DATA_W-1:0] s7_b_ff;
   logic signed [PROD_W-1:0] s7_p_iv_ff;
   logic signed [PROD_W-1:0] s7_p_iv_in;
   logic signed [PROD_W-1:0] s7_p_id_ff;
   logic signed [PROD_W-1:0] s7_p_id_in;
   logic signed [PROD_W-1:0] inv_sq;

   logic                     s8_below_ff;
   logic signed [DATA_W-1:0] s8_t_ff;
   logic signed [DATA_W-1:0] s8_a_ff;
   logic signed [DATA_W-1:0] s8_inner_ff;
   logic signed [DATA_W-1:0] s8_inner_in;
   logic signed [DATA_W-1:0] s8_der_ff;
   logic signed [DATA_W-1:0] s8_der_in;

   logic                     s9_below_ff;
   logic signed [DATA_W-1:0] s9_a_ff;
   logic signed [DATA_W-1:0] s9_der_ff;
   logic signed [PROD_W-1:0] s9_p_v_ff;
   logic signed [PROD_W-1:0] s9_p_v_in;

   always_comb begin
      vld_in = {vld_ff[LAST-1:1], acc.valid && (acc.cmd == CMD_QUERY)};

      s1_istep_in = ISTEP_W'(idx) * ISTEP_W'(cfg.step);

      t_wide  = $signed(WIDE_W'(s1_off_ff)) - $signed(WIDE_W'(s1_istep_ff));
      s2_t_in = sat32(t_wide);

      s3_p_td_in = PROD_W'(s2_t_ff) * PROD_W'(s2_coef_ff.d);
      s3_p_tc_in = PROD_W'(s2_t_ff) * PROD_W'(s2_coef_ff.c);
      s3_p_tt_in = PROD_W'(s2_t_ff) * PROD_W'(s2_t_ff);

      s4_sum_in = sat32(WIDE_W'(s3_coef_ff.c) + WIDE_W'(mulq(s3_p_td_ff)));
      s4_two_in = sat32(2 * WIDE_W'(mulq(s3_p_tc_ff)));
      s4_tt_in  = mulq(s3_p_tt_ff);

      s5_p_ts_in  = PROD_W'(s4_t_ff) * PROD_W'(s4_sum_ff);
      s5_p_ttd_in = PROD_W'(s4_tt_ff) * PROD_W'(s4_d_ff);

      s6_m2_in   = mulq(s5_p_ts_ff);
      three      = sat32(3 * WIDE_W'(mulq(s5_p_ttd_ff)));
      s6_sum3_in = sat32(WIDE_W'(s5_two_ff) + WIDE_W'(three));

      inv_sq     = PROD_W'($signed({1'b0, cfg.inv_step_sq}));
      s7_p_iv_in = PROD_W'(s6_m2_ff) * inv_sq;
      s7_p_id_in = PROD_W'(s6_sum3_ff) * inv_sq;

      s8_inner_in = sat32(WIDE_W'(s7_b_ff) + WIDE_W'(mulq(s7_p_iv_ff)));
      s8_der_in   = sat32(WIDE_W'(s7_b_ff) + WIDE_W'(mulq(s7_p_id_ff)));

      s9_p_v_in = PROD_W'(s8_t_ff) * PROD_W'(s8_inner_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_below_ff <= acc.below;
      s1_off_ff   <= acc.off;
      s1_istep_ff <= s1_istep_in;

      s2_below_ff <= s1_below_ff;
      s2_coef_ff  <= rd_coef;
      s2_t_ff     <= s2_t_in;

      s3_below_ff <= s2_below_ff;
      s3_t_ff     <= s2_t_ff;
      s3_coef_ff  <= s2_coef_ff;
      s3_p_td_ff  <= s3_p_td_in;
      s3_p_tc_ff  <= s3_p_tc_in;
      s3_p_tt_ff  <= s3_p_tt_in;

      s4_below_ff <= s3_below_ff;
      s4_t_ff     <= s3_t_ff;
      s4_a_ff     <= s3_coef_ff.a;
      s4_b_ff     <= s3_coef_ff.b;
      s4_d_ff     <= s3_coef_ff.d;
      s4_sum_ff   <= s4_sum_in;
      s4_two_ff   <= s4_two_in;
      s4_tt_ff    <= s4_tt_in;

      s5_below_ff <= s4_below_ff;
      s5_t_ff     <= s4_t_ff;
      s5_a_ff     <= s4_a_ff;
      s5_b_ff     <= s4_b_ff;
      s5_two_ff   <= s4_two_ff;
      s5_p_ts_ff  <= s5_p_ts_in;
      s5_p_ttd_ff <= s5_p_ttd_in;

      s6_below_ff <= s5_below_ff;
      s6_t_ff     <= s5_t_ff;
      s6_a_ff     <= s5_a_ff;
      s6_b_ff     <= s5_b_ff;
      s6_m2_ff    <= s6_m2_in;
      s6_sum3_ff  <= s6_sum3_in;

      s7_below_ff <= s6_below_ff;
      s7_t_ff     <= s6_t_ff;
      s7_a_ff     <= s6_a_ff;
      s7_b_ff     <= s6_b_ff;
      s7_p_iv_ff  <= s7_p_iv_in;
      s7_p_id_ff  <= s7_p_id_in;

      s8_below_ff <= s7_below_ff;
      s8_t_ff     <= s7_t_ff;
      s8_a_ff     <= s7_a_ff;
      s8_inner_ff <= s8_inner_in;
      s8_der_ff   <= s8_der_in;

      s9_below_ff <= s8_below_ff;
      s9_a_ff     <= s8_a_ff;
      s9_der_ff   <= s8_der_ff;
      s9_p_v_ff   <= s9_p_v_in;
   end

   always_comb begin
      out_valid            = vld_ff[LAST];
      out_item.value       = sat32(WIDE_W'(s9_a_ff) + WIDE_W'(mulq(s9_p_v_ff)));
      out_item.derivative  = s9_der_ff;
      out_item.below_range = s9_below_ff;
   end

   // A result leaves the chain only for a query whose table read entered its first stage.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] |-> $past(vld_ff[1], LAST - 1))
      else $error("eval pipeline produced a result without a matching query");

endmodule

// ===== design/chte_rsp_fifo.sv =====
module chte_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   claim,
   output logic                   has_room,
   input  logic                   push,
   input  chte_pkg::rsp_item_type push_item,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output chte_pkg::rsp_item_type pop_item
);

   import chte_pkg::*;

   rsp_item_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;
   logic [FIFO_CNT_W-1:0]   occ_ff;
   logic [FIFO_CNT_W-1:0]   occ_in;
   logic                    pop;

   // occ counts queries taken in and not yet handed out, so every query in
   // flight already owns a slot here.
   always_comb begin
      pop       = pop_valid && pop_ready;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      occ_in    = occ_ff + FIFO_CNT_W'(claim) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign has_room  = occ_ff < FIFO_CNT_W'(FIFO_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = mem_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= occ_ff)
      else $error("response buffer holds more results than outstanding queries");

   assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < FIFO_CNT_W'(FIFO_DEPTH))
      else $error("response buffer written while full");

endmodule

// ===== design/cubic_hermite_table_eval_unit.sv =====
// Cubic Hermite spline lookup with a table of four coefficients per mesh interval.
// req carries one item per transfer: req_tuser is the command, a write loads
// coef_a..coef_d into entry entry_index, a query evaluates the spline at x_in.
// rsp returns one item per query (value, derivative, below_range) in request
// order; writes return nothing. csr writes the five range and step registers
// and is always ready; the user must write it only while no query is in flight,
// which the block does not enforce. Throughput is one item per cycle while
// req_tready is high. A query's result is offered on rsp once it has passed the
// stages that clamp the abscissa and find the interval through the reciprocal
// multiply, the coefficient RAM read and the chain of registered multiplies.
// Writes pass through the same stages and reach the RAM in request order, so
// a query always sees every earlier write.
// Results collect in a 16-entry response buffer; req_tready drops while 16
// queries are outstanding, counting those still in the pipeline and those
// waiting in the buffer, so a stalled receiver backs up the input once 16
// queries have been taken in and not yet handed out.
// Reset empties the pipeline and the buffer and restores the register defaults;
// the coefficient table is undefined until written.
module cubic_hermite_table_eval_unit #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_index, coef_a, coef_b, coef_c, coef_d, x_in, zero fill
   input  logic [chte_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // cmd
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // value, derivative
   output logic [chte_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // below_range
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [chte_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [chte_pkg::DATA_W-1:0]        csr_data
);

   import chte_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

   cfg_type                  cfg_ff;
   cfg_type                  cfg_in;
   cmd_type                  req_cmd;
   logic [ENTRY_W-1:0]       req_entry;
   coef_type                 req_coef;
   logic signed [DATA_W-1:0] req_x;
   logic                     req_xfer;
   logic                     claim;
   logic                     has_room;

   access_type               acc;
   logic [ADDR_W-1:0]        idx;
   logic [ADDR_W-1:0]        entry_addr;
   coef_type                 wr_coef;
   coef_type                 rd_coef;
   logic                     ram_wr_en;
   logic                     ram_rd_en;

   logic                     eval_valid;
   rsp_item_type             eval_item;
   rsp_item_type             pop_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_X_LOW:       cfg_in.x_low       = csr_data;
            CSR_X_HIGH:      cfg_in.x_high      = csr_data;
            CSR_STEP:        cfg_in.step        = csr_data[STEP_W-1:0];
            CSR_INV_STEP:    cfg_in.inv_step    = csr_data;
            CSR_INV_STEP_SQ: cfg_in.inv_step_sq = csr_data;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_cmd    = cmd_type'(req_tuser);
      req_entry  = req_tdata[ENTRY_W-1:0];
      req_coef.a = req_tdata[ENTRY_W +: DATA_W];
      req_coef.b = req_tdata[ENTRY_W + DATA_W +: DATA_W];
      req_coef.c = req_tdata[ENTRY_W + 2*DATA_W +: DATA_W];
      req_coef.d = req_tdata[ENTRY_W + 3*DATA_W +: DATA_W];
      req_x      = req_tdata[ENTRY_W + 4*DATA_W +: DATA_W];
      req_xfer   = req_tvalid && req_tready;
      claim      = req_xfer && (req_cmd == CMD_QUERY);
   end

   assign req_tready = has_room;

   chte_locate #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_locate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_xfer),
      .in_cmd     (req_cmd),
      .in_entry   (req_entry),
      .in_coef    (req_coef),
      .in_x       (req_x),
      .cfg        (cfg_ff),
      .acc        (acc),
      .idx        (idx),
      .entry_addr (entry_addr),
      .coef       (wr_coef)
   );

   assign ram_wr_en = acc.valid && (acc.cmd == CMD_WRITE) && acc.wr_ok;
   assign ram_rd_en = acc.valid && (acc.cmd == CMD_QUERY);

   chte_ram #(
      .WIDTH($bits(coef_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (entry_addr),
      .wr_data (wr_coef),
      .rd_en   (ram_rd_en),
      .rd_addr (idx),
      .rd_data (rd_coef)
   );

   chte_eval #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .acc       (acc),
      .idx       (idx),
      .rd_coef   (rd_coef),
      .cfg       (cfg_ff),
      .out_valid (eval_valid),
      .out_item  (eval_item)
   );

   chte_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .claim     (claim),
      .has_room  (has_room),
      .push      (eval_valid),
      .push_item (eval_item),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_item  (pop_item)
   );

   assign rsp_tdata = {pop_item.derivative, pop_item.value};
   assign rsp_tuser = pop_item.below_range;

   assert property (@(posedge clock) disable iff (reset)
      eval_valid |-> $past(ram_rd_en, 9))
      else $error("result left the pipeline without a table read");

endmodule
